FILE: sv/cplc_pkg.sv
// package for the channel piecewise linear correction block
// types, widths and status codes used by all modules but cplc_ram; no dependencies

package cplc_pkg;

   localparam int CHANNELS  = 256;
   localparam int SPACERS   = 6;
   localparam int POS_W     = 20;
   localparam int ENTRY_W   = 16;
   localparam int MAG_W     = 16;
   localparam int SPAN_W    = 20;
   localparam int Q_W       = 17;
   localparam int PROD_W    = MAG_W + SPAN_W;
   localparam int IDX_W     = 3;
   localparam int STATUS_W  = 2;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_LOADED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_MATCH   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNUSED     = 2'd3;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic                      valid;
      logic                      force_lo;
      logic                      neg;
      logic signed [ENTRY_W-1:0] lo;
      logic [STATUS_W-1:0]       status;
   } side_type;

   typedef struct packed {
      side_type          side;
      logic [SPAN_W-1:0] rem;
      logic [Q_W-1:0]    quo;
      logic [Q_W-1:0]    low_bits;
      logic [SPAN_W-1:0] span;
   } div_stage_type;

endpackage

FILE: sv/cplc_ram.sv
// generic single write port ram with registered read
// no dependencies

module cplc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/cplc_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on cplc_pkg

module cplc_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  cplc_pkg::side_type              in_side,
   input  logic [cplc_pkg::PROD_W-1:0]     in_prod,
   input  logic [cplc_pkg::SPAN_W-1:0]     in_span,
   output cplc_pkg::side_type              out_side,
   output logic [cplc_pkg::Q_W-1:0]        out_quo
);

   localparam int QW = cplc_pkg::Q_W;
   localparam int SW = cplc_pkg::SPAN_W;

   cplc_pkg::div_stage_type head;
   cplc_pkg::div_stage_type stg_ff [QW];
   cplc_pkg::div_stage_type stg_in [QW];

   always_comb begin
      head          = '0;
      head.side     = in_side;
      head.rem      = SW'(in_prod[cplc_pkg::PROD_W-1:QW]);
      head.low_bits = in_prod[QW-1:0];
      head.span     = in_span;
   end

   for (genvar j = 0; j < QW; j++) begin : g_stage
      cplc_pkg::div_stage_type prev;
      logic [SW:0]             trial;
      logic                    ge;

      assign prev  = (j == 0) ? head : stg_ff[(j == 0) ? 0 : j-1];
      assign trial = {prev.rem, prev.low_bits[QW-1-j]};
      assign ge    = (trial >= {1'b0, prev.span});

      always_comb begin
         stg_in[j]     = prev;
         stg_in[j].rem = ge ? SW'(trial - {1'b0, prev.span}) : trial[SW-1:0];
         stg_in[j].quo = {prev.quo[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[j].side.valid <= 1'b0;
         end else if (advance) begin
            stg_ff[j] <= stg_in[j];
         end
      end
   end

   assign out_side = stg_ff[QW-1].side;
   assign out_quo  = stg_ff[QW-1].quo;

endmodule

FILE: sv/channel_piecewise_linear_correction_top.sv
// per-channel piecewise linear correction, top level
// depends on cplc_pkg, cplc_ram, cplc_div
//
//  port group | handshake            | word
//  req        | req_valid/req_stall  | type, channel, spacer index, entry value, position
//  rsp        | rsp_valid/rsp_stall  | correction, status (queries only)
//  csr        | apb, pready tied     | six 20-bit spacer positions at 4*i
//
// one word per cycle unless rsp_stall or the clearing pass holds it; a query reads the
// table at its edge, then passes difference, multiply, 17 divider stages, output register
// after reset req_stall stays high while the present ram is cleared
// the whole pipeline holds while rsp_valid is high and rsp_stall is high

module channel_piecewise_linear_correction_top #(
   parameter int CHANNELS = cplc_pkg::CHANNELS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_type,
   input  logic [7:0]                            req_channel,
   input  logic [cplc_pkg::IDX_W-1:0]            req_spacer_index,
   input  logic signed [cplc_pkg::ENTRY_W-1:0]   req_entry_value,
   input  logic signed [cplc_pkg::POS_W-1:0]     req_position,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [cplc_pkg::ENTRY_W-1:0]   rsp_correction,
   output logic [cplc_pkg::STATUS_W-1:0]         rsp_status,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [cplc_pkg::CSR_AW-1:0]           paddr,
   input  logic [cplc_pkg::CSR_DW-1:0]           pwdata,
   output logic [cplc_pkg::CSR_DW-1:0]           prdata,
   output logic                                  pready
);

   localparam int AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int NS  = cplc_pkg::SPACERS;
   localparam int PW  = cplc_pkg::POS_W;
   localparam int EW  = cplc_pkg::ENTRY_W;
   localparam int SW  = cplc_pkg::SPAN_W;
   localparam int QW  = cplc_pkg::Q_W;
   localparam int XW  = cplc_pkg::IDX_W;
   localparam int STW = cplc_pkg::STATUS_W;

   // spacer registers
   logic signed [PW-1:0] spacer_ff [NS];
   logic [XW-1:0]        csr_idx;
   logic                 csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = paddr[XW+1:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            spacer_ff[i] <= '0;
         end
      end else if (csr_wr && (32'(csr_idx) < 32'(NS))) begin
         spacer_ff[csr_idx] <= pwdata[PW-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (32'(csr_idx) < 32'(NS)) begin
         prdata = cplc_pkg::CSR_DW'(unsigned'(spacer_ff[csr_idx]));
      end
   end

   // flow control and present clearing pass
   logic          advance;
   logic          accept;
   logic          clearing_ff;
   logic [AW-1:0] clr_ptr_ff;
   logic          out_valid_ff;

   assign advance   = !(out_valid_ff && rsp_stall);
   assign req_stall = clearing_ff || !advance;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ptr_ff  <= '0;
      end else if (clearing_ff) begin
         clr_ptr_ff <= clr_ptr_ff + 1'b1;
         if (clr_ptr_ff == AW'(CHANNELS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // stage 0: table access and segment search
   logic          in_range;
   logic [AW-1:0] ch_addr;
   logic          is_write;
   logic          idx_ok;

   assign in_range = (32'(req_channel) < 32'(CHANNELS));
   assign ch_addr  = AW'(req_channel);
   assign is_write = accept && (req_type == cplc_pkg::REQ_WRITE) && in_range;
   assign idx_ok   = (32'(req_spacer_index) < 32'(NS));

   logic [EW-1:0] entry_rd [NS];
   logic          present_rd;

   for (genvar k = 0; k < NS; k++) begin : g_table
      cplc_ram #(
         .WIDTH (EW),
         .DEPTH (CHANNELS)
      ) u_table (
         .clock   (clock),
         .wr_en   (is_write && (req_spacer_index == XW'(k))),
         .wr_addr (ch_addr),
         .wr_data (req_entry_value),
         .rd_en   (advance),
         .rd_addr (ch_addr),
         .rd_data (entry_rd[k])
      );
   end

   cplc_ram #(
      .WIDTH (1),
      .DEPTH (CHANNELS)
   ) u_present (
      .clock   (clock),
      .wr_en   (clearing_ff || (is_write && idx_ok)),
      .wr_addr (clearing_ff ? clr_ptr_ff : ch_addr),
      .wr_data (!clearing_ff),
      .rd_en   (advance),
      .rd_addr (ch_addr),
      .rd_data (present_rd)
   );

   logic          sel_force_lo;
   logic          sel_none;
   logic [XW-1:0] sel_lo_idx;
   logic [PW:0]   sel_offset;
   logic [PW:0]   sel_span;

   always_comb begin
      sel_force_lo = 1'b1;
      sel_none     = 1'b0;
      sel_lo_idx   = '0;
      sel_offset   = '0;
      sel_span     = '0;
      if (req_position < spacer_ff[0]) begin
         sel_lo_idx = '0;
      end else if (req_position > spacer_ff[NS-1]) begin
         sel_lo_idx = XW'(NS - 1);
      end else begin
         sel_none = 1'b1;
         for (int i = NS - 1; i >= 1; i--) begin
            if (spacer_ff[i-1] <= req_position && spacer_ff[i] >= req_position) begin
               sel_none   = 1'b0;
               sel_lo_idx = XW'(i - 1);
               sel_offset = (PW+1)'(req_position) - (PW+1)'(spacer_ff[i-1]);
               sel_span   = (PW+1)'(spacer_ff[i]) - (PW+1)'(spacer_ff[i-1]);
               sel_force_lo = (spacer_ff[i] == spacer_ff[i-1]);
            end
         end
      end
   end

   logic          s1_valid_ff;
   logic          s1_in_range_ff;
   logic          s1_none_ff;
   logic          s1_force_lo_ff;
   logic [XW-1:0] s1_lo_idx_ff;
   logic [SW-1:0] s1_offset_ff;
   logic [SW-1:0] s1_span_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept && (req_type == cplc_pkg::REQ_QUERY);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_in_range_ff <= in_range;
         s1_none_ff     <= sel_none;
         s1_force_lo_ff <= sel_force_lo;
         s1_lo_idx_ff   <= sel_lo_idx;
         s1_offset_ff   <= sel_offset[SW-1:0];
         s1_span_ff     <= sel_span[SW-1:0];
      end
   end

   // stage 1: pick entries, difference and status
   logic signed [EW-1:0] lo_val;
   logic signed [EW-1:0] hi_val;
   logic signed [EW:0]   diff;
   logic [EW:0]          diff_mag;
   cplc_pkg::side_type   s1_side;

   always_comb begin
      lo_val = entry_rd[0];
      hi_val = entry_rd[0];
      case (s1_lo_idx_ff)
         3'd0: begin
            lo_val = entry_rd[0];
            hi_val = entry_rd[1];
         end
         3'd1: begin
            lo_val = entry_rd[1];
            hi_val = entry_rd[2];
         end
         3'd2: begin
            lo_val = entry_rd[2];
            hi_val = entry_rd[3];
         end
         3'd3: begin
            lo_val = entry_rd[3];
            hi_val = entry_rd[4];
         end
         3'd4: begin
            lo_val = entry_rd[4];
            hi_val = entry_rd[5];
         end
         3'd5: begin
            lo_val = entry_rd[5];
            hi_val = entry_rd[5];
         end
         default: begin
            lo_val = entry_rd[0];
            hi_val = entry_rd[0];
         end
      endcase
      diff     = (EW+1)'(hi_val) - (EW+1)'(lo_val);
      diff_mag = diff[EW] ? (EW+1)'(-diff) : diff;

      s1_side          = '0;
      s1_side.valid    = s1_valid_ff;
      s1_side.force_lo = s1_force_lo_ff;
      s1_side.neg      = diff[EW];
      s1_side.lo       = lo_val;
      if (!s1_in_range_ff || !present_rd) begin
         s1_side.status = cplc_pkg::STATUS_NOT_LOADED;
      end else if (s1_none_ff) begin
         s1_side.status = cplc_pkg::STATUS_NO_MATCH;
      end else begin
         s1_side.status = cplc_pkg::STATUS_OK;
      end
   end

   cplc_pkg::side_type                 s2_side_ff;
   logic [cplc_pkg::MAG_W-1:0]         s2_mag_ff;
   logic [SW-1:0]                      s2_offset_ff;
   logic [SW-1:0]                      s2_span_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_side_ff.valid <= 1'b0;
      end else if (advance) begin
         s2_side_ff <= s1_side;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_mag_ff    <= diff_mag[cplc_pkg::MAG_W-1:0];
         s2_offset_ff <= s1_offset_ff;
         s2_span_ff   <= s1_span_ff;
      end
   end

   // stage 2: multiply
   cplc_pkg::side_type                 s3_side_ff;
   logic [cplc_pkg::PROD_W-1:0]        s3_prod_ff;
   logic [SW-1:0]                      s3_span_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_side_ff.valid <= 1'b0;
      end else if (advance) begin
         s3_side_ff <= s2_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_prod_ff <= cplc_pkg::PROD_W'(s2_mag_ff) * cplc_pkg::PROD_W'(s2_offset_ff);
         s3_span_ff <= s2_span_ff;
      end
   end

   // divider stages
   cplc_pkg::side_type div_side;
   logic [QW-1:0]      div_quo;

   cplc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_side  (s3_side_ff),
      .in_prod  (s3_prod_ff),
      .in_span  (s3_span_ff),
      .out_side (div_side),
      .out_quo  (div_quo)
   );

   // output register
   logic [QW:0]          signed_quo;
   logic [QW:0]          sum;
   logic signed [EW-1:0] corr_in;
   logic signed [EW-1:0] corr_ff;
   logic [STW-1:0]       status_ff;

   always_comb begin
      signed_quo = div_side.neg ? (QW+1)'(-{1'b0, div_quo}) : {1'b0, div_quo};
      sum        = (QW+1)'(div_side.lo) + signed_quo;
      if (div_side.status != cplc_pkg::STATUS_OK) begin
         corr_in = '0;
      end else if (div_side.force_lo) begin
         corr_in = div_side.lo;
      end else begin
         corr_in = sum[EW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= div_side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         corr_ff   <= corr_in;
         status_ff <= div_side.status;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_correction = corr_ff;
   assign rsp_status     = status_ff;

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> req_stall)
      else $error("item taken during present clearing");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != cplc_pkg::STATUS_OK |-> rsp_correction == '0)
      else $error("nonzero correction on error status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != cplc_pkg::STATUS_UNUSED)
      else $error("unused status code");

   a_hold_s1: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(s1_valid_ff) && $stable(out_valid_ff))
      else $error("pipeline moved while held");

endmodule

FILE: tb/cplc_checker.sv
// checker for the channel piecewise linear correction block
// watches the req, rsp and csr ports, predicts each query answer and compares
// depends on cplc_pkg

module cplc_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic                                  req_type,
   input  logic [7:0]                            req_channel,
   input  logic [cplc_pkg::IDX_W-1:0]            req_spacer_index,
   input  logic signed [cplc_pkg::ENTRY_W-1:0]   req_entry_value,
   input  logic signed [cplc_pkg::POS_W-1:0]     req_position,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic signed [cplc_pkg::ENTRY_W-1:0]   rsp_correction,
   input  logic [cplc_pkg::STATUS_W-1:0]         rsp_status,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic                                  pready,
   input  logic [cplc_pkg::CSR_AW-1:0]           paddr,
   input  logic [cplc_pkg::CSR_DW-1:0]           pwdata,
   output int                                    fail_count,
   output int                                    pending
);

   typedef struct {
      logic signed [cplc_pkg::ENTRY_W-1:0] correction;
      logic [cplc_pkg::STATUS_W-1:0]       status;
   } answer_type;

   logic signed [cplc_pkg::POS_W-1:0]   spacer_pos [cplc_pkg::SPACERS];
   logic signed [cplc_pkg::ENTRY_W-1:0] corr_table [cplc_pkg::CHANNELS][cplc_pkg::SPACERS];
   logic                                present    [cplc_pkg::CHANNELS];
   answer_type                          expected_answers [$];

   function automatic answer_type interpolate(input int ch,
                                              input logic signed [cplc_pkg::POS_W-1:0] pos);
      answer_type a;
      longint     lo, span, diff, c;
      a.correction = '0;
      a.status = cplc_pkg::STATUS_NO_MATCH;
      if (!present[ch]) begin
         a.status = cplc_pkg::STATUS_NOT_LOADED;
      end else if (pos < spacer_pos[0]) begin
         a.correction = corr_table[ch][0];
         a.status = cplc_pkg::STATUS_OK;
      end else if (pos > spacer_pos[cplc_pkg::SPACERS-1]) begin
         a.correction = corr_table[ch][cplc_pkg::SPACERS-1];
         a.status = cplc_pkg::STATUS_OK;
      end else begin
         for (int i = 1; i < cplc_pkg::SPACERS; i++) begin
            if (a.status == cplc_pkg::STATUS_NO_MATCH &&
                spacer_pos[i-1] <= pos && spacer_pos[i] >= pos) begin
               lo = corr_table[ch][i-1];
               span = longint'(spacer_pos[i]) - longint'(spacer_pos[i-1]);
               if (span == 0) begin
                  c = lo;
               end else begin
                  diff = longint'(corr_table[ch][i]) - lo;
                  c = lo + (diff * (longint'(pos) - longint'(spacer_pos[i-1]))) / span;
               end
               a.correction = c[cplc_pkg::ENTRY_W-1:0];
               a.status = cplc_pkg::STATUS_OK;
            end
         end
      end
      return a;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      answer_type a;
      if (reset) begin
         for (int i = 0; i < cplc_pkg::SPACERS; i++) spacer_pos[i] = '0;
         for (int c = 0; c < cplc_pkg::CHANNELS; c++) present[c] = 1'b0;
         expected_answers.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00 &&
             (paddr >> 2) < cplc_pkg::SPACERS)
            spacer_pos[paddr >> 2] = pwdata[cplc_pkg::POS_W-1:0];
         if (rsp_valid && !rsp_stall) begin
            if (expected_answers.size() == 0) begin
               report("unexpected word, correction", rsp_correction, 0);
            end else begin
               a = expected_answers.pop_front();
               if (rsp_correction !== a.correction)
                  report("correction", rsp_correction, a.correction);
               if (rsp_status !== a.status)
                  report("status", rsp_status, a.status);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_type == cplc_pkg::REQ_WRITE) begin
               if (req_spacer_index < cplc_pkg::SPACERS) begin
                  corr_table[req_channel][req_spacer_index] = req_entry_value;
                  present[req_channel] = 1'b1;
               end
            end else begin
               expected_answers.push_back(interpolate(req_channel, req_position));
            end
         end
      end
      pending = expected_answers.size();
   end

endmodule

FILE: tb/testbench.sv
// top of the channel piecewise linear correction testbench
// drives req and csr words and the rsp stall, gives the verdict
// depends on cplc_pkg, channel_piecewise_linear_correction_top, cplc_checker

module testbench;

   localparam int LIMIT = 400000;
   localparam int DRAIN = 40;

   logic clock, reset;
   logic req_valid, req_stall, req_type;
   logic [7:0] req_channel;
   logic [cplc_pkg::IDX_W-1:0] req_spacer_index;
   logic signed [cplc_pkg::ENTRY_W-1:0] req_entry_value;
   logic signed [cplc_pkg::POS_W-1:0] req_position;
   logic rsp_valid, rsp_stall;
   logic signed [cplc_pkg::ENTRY_W-1:0] rsp_correction;
   logic [cplc_pkg::STATUS_W-1:0] rsp_status;
   logic psel, penable, pwrite, pready;
   logic [cplc_pkg::CSR_AW-1:0] paddr;
   logic [cplc_pkg::CSR_DW-1:0] pwdata, prdata;
   int fail_count, pending;

   int send_idle_pct, stall_pct;
   int cycles = 0;
   logic hold_go;
   logic hold_done = 1'b0;
   int hold_left = 0;
   logic loaded [cplc_pkg::CHANNELS];
   logic signed [cplc_pkg::POS_W-1:0] spacers [cplc_pkg::SPACERS];

   channel_piecewise_linear_correction_top u_dut (.*);

   cplc_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver stall, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_done = 1'b1;
         hold_left = 400;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
      end
      rsp_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
   end

   task automatic csr_write(input int idx, input int val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= cplc_pkg::CSR_AW'(idx * 4);
      pwdata <= cplc_pkg::CSR_DW'(val);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      spacers[idx] = cplc_pkg::POS_W'(val);
   endtask

   task automatic load_spacers(input int p0, p1, p2, p3, p4, p5);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (DRAIN) @(posedge clock);
      csr_write(0, p0); csr_write(1, p1); csr_write(2, p2);
      csr_write(3, p3); csr_write(4, p4); csr_write(5, p5);
   endtask

   task automatic send_word(input logic t, input int ch, input int idx, input int val,
                            input int pos);
      req_valid <= 1'b1;
      req_type <= t;
      req_channel <= 8'(ch);
      req_spacer_index <= cplc_pkg::IDX_W'(idx);
      req_entry_value <= cplc_pkg::ENTRY_W'(val);
      req_position <= cplc_pkg::POS_W'(pos);
      do @(posedge clock); while (req_stall);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic load_channel(input int ch);
      for (int k = 0; k < cplc_pkg::SPACERS; k++)
         send_word(cplc_pkg::REQ_WRITE, ch, k, $urandom_range(65535), $urandom_range(1048575));
      loaded[ch] = 1'b1;
   endtask

   function automatic int pick_position();
      int r, k;
      r = $urandom_range(99);
      k = $urandom_range(cplc_pkg::SPACERS-1);
      if (r < 25) return int'(spacers[k]) + int'($urandom_range(2)) - 1;
      if (r < 35) return $urandom_range(1) ? -524288 : 524287;
      if (r < 70) return $signed(20'($urandom_range(1048575)));
      return int'(spacers[k]) + int'($urandom_range(4000)) - 2000;
   endfunction

   task automatic random_words(input int n);
      int r, ch;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         ch = $urandom_range(cplc_pkg::CHANNELS-1);
         if (r < 12) begin
            load_channel(ch);
         end else if (r < 18) begin
            send_word(cplc_pkg::REQ_WRITE, ch, $urandom_range(7, 6), $urandom_range(65535),
                      $urandom_range(1048575));
         end else if (r < 28 && loaded[ch]) begin
            send_word(cplc_pkg::REQ_WRITE, ch, $urandom_range(5), $urandom_range(65535),
                      $urandom_range(1048575));
         end else begin
            if (r < 85) begin
               for (int s = 0; s < 8 && !loaded[ch]; s++)
                  ch = $urandom_range(cplc_pkg::CHANNELS-1);
            end
            send_word(cplc_pkg::REQ_QUERY, ch, $urandom_range(7), $urandom_range(65535),
                      pick_position());
         end
      end
   endtask

   function automatic int rand_pos();
      return $signed(20'($urandom_range(1048575)));
   endfunction

   initial begin
      int sorted [cplc_pkg::SPACERS];
      int tmp;
      hold_go = 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      for (int c = 0; c < cplc_pkg::CHANNELS; c++) loaded[c] = 1'b0;
      for (int k = 0; k < cplc_pkg::SPACERS; k++) spacers[k] = '0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_type <= cplc_pkg::REQ_WRITE;
      req_channel <= '0;
      req_spacer_index <= '0;
      req_entry_value <= '0;
      req_position <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: reset spacers, not loaded, ignored indexes, extremes
      send_word(cplc_pkg::REQ_QUERY, 7, 0, 0, 0);
      send_word(cplc_pkg::REQ_WRITE, 9, 6, 100, 0);
      send_word(cplc_pkg::REQ_WRITE, 9, 7, -100, 0);
      send_word(cplc_pkg::REQ_QUERY, 9, 0, 0, 5);
      send_word(cplc_pkg::REQ_WRITE, 0, 0, -32768, 0);
      send_word(cplc_pkg::REQ_WRITE, 0, 1, 32767, 0);
      send_word(cplc_pkg::REQ_WRITE, 0, 2, -32768, 0);
      send_word(cplc_pkg::REQ_WRITE, 0, 3, 32767, 0);
      send_word(cplc_pkg::REQ_WRITE, 0, 4, 0, 0);
      send_word(cplc_pkg::REQ_WRITE, 0, 5, 32767, 0);
      loaded[0] = 1'b1;
      send_word(cplc_pkg::REQ_QUERY, 0, 0, 0, 0);
      send_word(cplc_pkg::REQ_QUERY, 0, 0, 0, -524288);
      send_word(cplc_pkg::REQ_QUERY, 0, 0, 0, 524287);
      load_channel(255);
      load_spacers(-524288, -200000, -1, 0, 0, 524287);
      send_word(cplc_pkg::REQ_QUERY, 0, 0, 0, -524288);
      send_word(cplc_pkg::REQ_QUERY, 0, 0, 0, 524287);
      send_word(cplc_pkg::REQ_QUERY, 0, 0, 0, 0);
      send_word(cplc_pkg::REQ_QUERY, 0, 0, 0, -100001);
      send_word(cplc_pkg::REQ_QUERY, 255, 0, 0, 300000);
      send_word(cplc_pkg::REQ_QUERY, 255, 0, 0, -1);
      load_spacers(500, 100, 900, -300, 2000, 1000);
      send_word(cplc_pkg::REQ_QUERY, 0, 0, 0, 1500);
      send_word(cplc_pkg::REQ_QUERY, 0, 0, 0, 950);

      for (int ph = 0; ph < 5; ph++) begin
         for (int k = 0; k < cplc_pkg::SPACERS; k++)
            sorted[k] = rand_pos() >>> (ph % 3) * 6;
         if (ph != 4) begin
            for (int a = 0; a < cplc_pkg::SPACERS; a++)
               for (int b = a + 1; b < cplc_pkg::SPACERS; b++)
                  if (sorted[b] < sorted[a]) begin
                     tmp = sorted[a]; sorted[a] = sorted[b]; sorted[b] = tmp;
                  end
         end
         if (ph == 1) sorted[3] = sorted[2];
         load_spacers(sorted[0], sorted[1], sorted[2], sorted[3], sorted[4], sorted[5]);
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 87; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 87; end
            3: begin send_idle_pct = 19; stall_pct = 19; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         if (ph == 0) hold_go = 1'b1;
         random_words(48);
         if (ph == 3) begin
            req_valid <= 1'b0;
            @(posedge clock);
            wait (pending == 0);
            @(posedge clock);
         end
         random_words(48);
      end
      req_valid <= 1'b0;
      @(posedge clock);

      wait (pending == 0);
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/cplc_pkg.sv
sv/cplc_ram.sv
sv/cplc_div.sv
sv/channel_piecewise_linear_correction_top.sv
tb/cplc_checker.sv
tb/testbench.sv
